### rtl/cwm_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the cosine window multiplier.
// No dependencies; the coefficient engine, datapath and top level import this package.
package cwm_pkg;

  localparam int SampleW = 16;
  localparam int PosW    = 12;
  localparam int LenW    = 13;
  localparam int KindW   = 2;
  localparam int CoefW   = 18;
  localparam int RegIdxW = 1;

  // coefficient table covers every position the input field can carry
  localparam int TableDepth = 1 << PosW;

  localparam logic [KindW-1:0] KindHamming  = 2'd0;
  localparam logic [KindW-1:0] KindHann     = 2'd1;
  localparam logic [KindW-1:0] KindBlackman = 2'd2;

  localparam logic [RegIdxW-1:0] RegWindowKind  = 1'd0;
  localparam logic [RegIdxW-1:0] RegFrameLength = 1'd1;

  localparam logic [KindW-1:0] KindReset = KindHamming;
  localparam logic [LenW-1:0]  LenReset  = 13'd1024;

  // coefficient 1.0 in Q1.17
  localparam logic [CoefW-1:0] CoefOne = 18'd131072;

  // window constants in Q30
  localparam logic [30:0] K054 = 31'd579820585;
  localparam logic [30:0] K046 = 31'd493921239;
  localparam logic [30:0] K042 = 31'd450971566;
  localparam logic [30:0] K008 = 31'd85899346;
  localparam logic [30:0] K050 = 31'd536870912;

  // (pi/2)^(2k)/(2k)! in Q30, k = 0..6
  localparam logic [30:0] TaylorQ30 [7] = '{
    31'd1073741824, 31'd1324675879, 31'd272375560, 31'd22401992,
    31'd987048, 31'd27061, 31'd506
  };

  typedef struct packed {
    logic signed [SampleW-1:0] sample_value;
    logic [PosW-1:0]           position;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] windowed_value;
    logic                      position_error;
    logic                      frame_end;
  } out_item_t;

  typedef struct packed {
    logic [RegIdxW-1:0] index;
    logic [LenW-1:0]    data;
  } cfg_wr_t;

  // active window settings, frame length already clamped
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [LenW-1:0]  len;
  } win_cfg_t;

  typedef struct packed {
    logic             en;
    logic [PosW-1:0]  addr;
    logic [CoefW-1:0] data;
  } coef_wr_t;

endpackage

### rtl/cwm_chan_if.sv
`timescale 1ns / 1ps
// Valid/ready channel carrying one payload struct per transaction.
// Payload types come from cwm_pkg.
interface cwm_chan_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### rtl/cwm_coef_engine.sv
`timescale 1ns / 1ps
// Coefficient table builder: one shared multiplier sequenced over the cosine
// polynomial and window sum, writing one Q1.17 entry per position. Uses cwm_pkg.
module cwm_coef_engine (
  input  logic              clk,
  input  logic              rst,
  input  cwm_pkg::win_cfg_t wcfg,
  input  logic              restart,
  output cwm_pkg::coef_wr_t wr,
  output logic              table_ready
);
  import cwm_pkg::*;

  localparam logic [3:0] SStart = 4'd0;
  localparam logic [3:0] SDiv   = 4'd1;
  localparam logic [3:0] SCosZ  = 4'd2;
  localparam logic [3:0] SCosZW = 4'd3;
  localparam logic [3:0] SHMul  = 4'd4;
  localparam logic [3:0] SHAcc  = 4'd5;
  localparam logic [3:0] STerm  = 4'd6;
  localparam logic [3:0] STAcc  = 4'd7;
  localparam logic [3:0] SWrite = 4'd8;
  localparam logic [3:0] SDone  = 4'd9;

  localparam logic [4:0] DivBits = 5'd24;

  logic [3:0]         state;
  logic [13:0]        div_rem;
  logic [24:0]        div_quo;
  logic [4:0]         div_cnt;
  logic [23:0]        ph_q;
  logic [LenW-1:0]    ph_r;
  logic [PosW-1:0]    entry;
  logic               sel;
  logic               neg_c;
  logic [30:0]        z;
  logic [30:0]        acc;
  logic [2:0]         k;
  logic [61:0]        prod;
  logic signed [63:0] wacc;

  logic [LenW-1:0]    d;
  logic [LenW-1:0]    fill_len;
  logic               len_one;
  logic               last_entry;
  logic [30:0]        ka;
  logic signed [63:0] wbase;
  logic [30:0]        mul_a;
  logic [30:0]        mul_b;

  logic [23:0]        turn;
  logic [22:0]        rr;
  logic [13:0]        rem_sh;
  logic               div_ge;
  logic [31:0]        t;
  logic [30:0]        tk;
  logic [30:0]        acc_step;
  logic signed [63:0] term;
  logic signed [63:0] rnd;
  logic [CoefW-1:0]   coef;
  logic [LenW:0]      sum_r;
  logic               ph_ge;

  assign d          = LenW'(wcfg.len - 1'b1);
  assign fill_len   = (wcfg.len > LenW'(TableDepth)) ? LenW'(TableDepth) : wcfg.len;
  assign len_one    = (wcfg.len == LenW'(1));
  assign last_entry = (({1'b0, entry} + 1'b1) == fill_len);

  always_comb begin
    case (wcfg.kind)
      KindHamming: ka = K054;
      KindHann:    ka = K050;
      default:     ka = K042;
    endcase
  end
  assign wbase = $signed({3'b000, ka, 30'd0});

  // quarter-wave fold of the turn
  assign turn = sel ? {ph_q[22:0], 1'b0} : ph_q;
  assign rr   = turn[22] ? 23'(23'h400000 - {1'b0, turn[21:0]}) : {1'b0, turn[21:0]};

  assign rem_sh = {div_rem[12:0], (div_cnt == DivBits)};
  assign div_ge = (rem_sh >= {1'b0, d});

  assign t        = prod[61:30];
  assign tk       = TaylorQ30[k];
  assign acc_step = (t >= {1'b0, tk}) ? '0 : 31'({1'b0, tk} - t);

  assign term = $signed({2'b00, prod});
  assign rnd  = wacc + 64'sd4398046511104;
  assign coef = len_one ? CoefOne :
                ((!wacc[63] && (wacc != 64'sd0)) ? rnd[60:43] : '0);

  assign sum_r = {1'b0, ph_r} + {1'b0, div_rem[12:0]};
  assign ph_ge = (sum_r >= {1'b0, d});

  always_comb begin
    case (state)
      SCosZ: begin
        mul_a = {rr, 8'd0};
        mul_b = {rr, 8'd0};
      end
      SHMul: begin
        mul_a = acc;
        mul_b = z;
      end
      STerm: begin
        mul_a = sel ? K008 : ((wcfg.kind == KindHamming) ? K046 : K050);
        mul_b = acc;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign wr.en       = (state == SWrite);
  assign wr.addr     = entry;
  assign wr.data     = coef;
  assign table_ready = (state == SDone);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SStart;
    end else if (restart) begin
      state <= SStart;
    end else begin
      case (state)
        SStart: begin
          div_rem <= '0;
          div_quo <= '0;
          div_cnt <= DivBits;
          entry   <= '0;
          if (fill_len == '0) begin
            state <= SDone;
          end else if (len_one) begin
            state <= SWrite;
          end else begin
            state <= SDiv;
          end
        end
        SDiv: begin
          // one quotient bit of 2^24 / d per cycle
          div_rem <= div_ge ? 14'(rem_sh - {1'b0, d}) : rem_sh;
          div_quo <= {div_quo[23:0], div_ge};
          div_cnt <= div_cnt - 1'b1;
          if (div_cnt == '0) begin
            ph_q  <= '0;
            ph_r  <= d >> 1;
            sel   <= 1'b0;
            wacc  <= wbase;
            state <= SCosZ;
          end
        end
        SCosZ: begin
          neg_c <= turn[23] ^ turn[22];
          state <= SCosZW;
        end
        SCosZW: begin
          z     <= prod[60:30];
          acc   <= TaylorQ30[6];
          k     <= 3'd5;
          state <= SHMul;
        end
        SHMul: begin
          state <= SHAcc;
        end
        SHAcc: begin
          acc <= acc_step;
          if (k == '0) begin
            state <= STerm;
          end else begin
            k     <= k - 1'b1;
            state <= SHMul;
          end
        end
        STerm: begin
          state <= STAcc;
        end
        STAcc: begin
          wacc <= (neg_c ^ sel) ? (wacc + term) : (wacc - term);
          if (!sel && wcfg.kind[1]) begin
            sel   <= 1'b1;
            state <= SCosZ;
          end else begin
            state <= SWrite;
          end
        end
        SWrite: begin
          // advance the rounded phase by 2^24 / d
          ph_r  <= ph_ge ? LenW'(sum_r - {1'b0, d}) : sum_r[LenW-1:0];
          ph_q  <= 24'(ph_q + div_quo[23:0] + {23'd0, ph_ge});
          entry <= entry + 1'b1;
          sel   <= 1'b0;
          wacc  <= wbase;
          state <= last_entry ? SDone : SCosZ;
        end
        SDone: begin
          state <= SDone;
        end
        default: begin
          state <= SStart;
        end
      endcase
    end
  end

endmodule

### rtl/cwm_datapath.sv
`timescale 1ns / 1ps
// Coefficient memory and the three-stage sample pipeline: table read,
// multiply, round and saturate. Uses cwm_pkg and cwm_chan_if.
module cwm_datapath (
  input  logic              clk,
  input  logic              rst,
  input  cwm_pkg::win_cfg_t wcfg,
  input  logic              enable,
  input  cwm_pkg::coef_wr_t wr,
  cwm_chan_if.sink          samples,
  cwm_chan_if.source        results
);
  import cwm_pkg::*;

  logic [CoefW-1:0] coef_mem [TableDepth];

  logic             v1;
  logic             s1_neg;
  logic [16:0]      s1_mag;
  logic             s1_err;
  logic             s1_fend;
  logic [CoefW-1:0] s1_w;

  logic             v2;
  logic             s2_neg;
  logic             s2_err;
  logic             s2_fend;
  logic [34:0]      s2_prod;

  logic             o_valid;
  out_item_t        o_item;

  logic             adv1;
  logic             adv2;
  logic             adv3;
  logic             take;
  logic             in_neg;
  logic [16:0]      in_mag;
  logic [CoefW-1:0] w_eff;
  logic [35:0]      rsum;
  logic [18:0]      q;
  logic [SampleW-1:0] sat_val;

  assign adv3 = !o_valid || results.ready;
  assign adv2 = !v2 || adv3;
  assign adv1 = !v1 || adv2;

  assign samples.ready = enable && adv1;
  assign take          = samples.valid && samples.ready;

  assign in_neg = samples.payload.sample_value[SampleW-1];
  assign in_mag = in_neg ? 17'(17'h10000 - {1'b0, samples.payload.sample_value})
                         : {1'b0, samples.payload.sample_value};

  // table is filled only while samples are held off (enable low), so reads never
  // race a write to the same entry
  always_ff @(posedge clk) begin
    if (wr.en) begin
      coef_mem[wr.addr] <= wr.data;
    end
    if (take) begin
      s1_w <= coef_mem[samples.payload.position];
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_neg  <= in_neg;
      s1_mag  <= in_mag;
      s1_err  <= ({1'b0, samples.payload.position} >= wcfg.len);
      s1_fend <= (({1'b0, samples.payload.position} + 1'b1) == wcfg.len);
    end
  end

  assign w_eff = s1_err ? '0 : s1_w;

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_prod <= 35'(s1_mag * w_eff);
      s2_neg  <= s1_neg;
      s2_err  <= s1_err;
      s2_fend <= s1_fend && !s1_err;
    end
  end

  assign rsum = {1'b0, s2_prod} + 36'd65536;
  assign q    = rsum[35:17];

  always_comb begin
    if (s2_neg) begin
      sat_val = (q > 19'd32768) ? 16'h8000 : 16'(19'd0 - q);
    end else begin
      sat_val = (q > 19'd32767) ? 16'h7fff : q[SampleW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      o_item.windowed_value <= s2_err ? '0 : $signed(sat_val);
      o_item.position_error <= s2_err;
      o_item.frame_end      <= s2_fend;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= take;
      end
      if (adv2) begin
        v2 <= v1;
      end
      if (adv3) begin
        o_valid <= v2;
      end
    end
  end

  assign results.valid   = o_valid;
  assign results.payload = o_item;

endmodule

### rtl/cosine_window_multiplier.sv
`timescale 1ns / 1ps
// Cosine window multiplier: Hamming, Hann or Blackman weighting of a sample stream.
// Registered stages: table read, multiply, round. One sample per cycle sustained while
// results.ready is high. After reset and after every register write the coefficient
// table is rebuilt by one shared multiplier; samples are held off until it is done
// and while a register write is pending. Reset (synchronous): Hamming, length 1024.
module cosine_window_multiplier #(
  parameter int MAX_LENGTH = 4096
) (
  input logic        clk,
  input logic        rst,
  cwm_chan_if.sink   samples,
  cwm_chan_if.source results,
  cwm_chan_if.sink   cfg
);
  import cwm_pkg::*;

  logic [KindW-1:0] window_kind;
  logic [LenW-1:0]  frame_length;
  win_cfg_t         wcfg;
  coef_wr_t         wr;
  logic             table_ready;
  logic             cfg_take;

  assign cfg.ready = 1'b1;
  assign cfg_take  = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_kind  <= KindReset;
      frame_length <= LenReset;
    end else if (cfg_take) begin
      case (cfg.payload.index)
        RegWindowKind:  window_kind  <= cfg.payload.data[KindW-1:0];
        RegFrameLength: frame_length <= cfg.payload.data;
        default: ;
      endcase
    end
  end

  // clamp the frame length to the supported maximum
  assign wcfg.kind = window_kind;
  assign wcfg.len  = ({19'd0, frame_length} > 32'(MAX_LENGTH)) ? LenW'(MAX_LENGTH)
                                                                 : frame_length;

  cwm_coef_engine u_engine (
    .clk         (clk),
    .rst         (rst),
    .wcfg        (wcfg),
    .restart     (cfg_take),
    .wr          (wr),
    .table_ready (table_ready)
  );

  cwm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .wcfg    (wcfg),
    .enable  (table_ready && !cfg.valid),
    .wr      (wr),
    .samples (samples),
    .results (results)
  );

endmodule
